// ===== sv/srtt_pkg.sv =====
// Shared types and codes for the sorted range translation table.
package srtt_pkg;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_OVERLAP   = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_RANGE = 3'd4;

    typedef struct packed {
        logic load_new;
        logic take_left;
        logic take_right;
    } t_cell_ctl;

    typedef struct packed {
        logic overlap;
        logic below;
        logic match;
        logic hit;
    } t_cell_flags;

endpackage

// ===== sv/srtt_cell.sv =====
// One table cell: holds a region, compares it against the current word, shifts with neighbors.
module srtt_cell #(
    parameter int ADDR_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_occupied,
    input  logic                  i_eval,
    input  srtt_pkg::t_cell_ctl   i_ctl,
    input  logic [ADDR_BITS-1:0]  i_item_addr,
    input  logic [ADDR_BITS-1:0]  i_item_end,
    input  logic [7:0]            i_item_id,
    input  logic [ADDR_BITS-1:0]  i_left_base,
    input  logic [ADDR_BITS-1:0]  i_left_end,
    input  logic [7:0]            i_left_tag,
    input  logic [ADDR_BITS-1:0]  i_right_base,
    input  logic [ADDR_BITS-1:0]  i_right_end,
    input  logic [7:0]            i_right_tag,
    output logic [ADDR_BITS-1:0]  o_base,
    output logic [ADDR_BITS-1:0]  o_end,
    output logic [7:0]            o_tag,
    output srtt_pkg::t_cell_flags o_flags
);
    import srtt_pkg::*;

    logic [ADDR_BITS-1:0] r_base;
    logic [ADDR_BITS-1:0] r_end;
    logic [7:0]           r_tag;
    t_cell_flags          r_flags;
    t_cell_flags          n_flags;

    always_comb begin
        n_flags.overlap = i_occupied && (r_base < i_item_end) && (i_item_addr < r_end);
        n_flags.below   = i_occupied && (r_end <= i_item_addr);
        n_flags.match   = i_occupied && (r_base == i_item_addr);
        n_flags.hit     = i_occupied && (r_base <= i_item_addr) && (i_item_addr < r_end);
    end

    always_ff @(posedge i_clk) begin
        if (i_eval) begin
            r_flags <= n_flags;
        end
        if (i_ctl.load_new) begin
            r_base <= i_item_addr;
            r_end  <= i_item_end;
            r_tag  <= i_item_id;
        end else if (i_ctl.take_left) begin
            r_base <= i_left_base;
            r_end  <= i_left_end;
            r_tag  <= i_left_tag;
        end else if (i_ctl.take_right) begin
            r_base <= i_right_base;
            r_end  <= i_right_end;
            r_tag  <= i_right_tag;
        end
    end

    assign o_base  = r_base;
    assign o_end   = r_end;
    assign o_tag   = r_tag;
    assign o_flags = r_flags;

endmodule

// ===== sv/sorted_range_translation_table_core.sv =====
// Sorted region table: a row of cells holding non-overlapping [base, end) regions in base order.
// A word is accepted, then in the EVAL state every cell compares its region against it, and in
// the APPLY state the result is written and the row shifts by one cell to insert or close a gap.
// The next word is accepted in the same cycle that commits the previous one, once the result
// register is free. Each cell carries its own comparators, so the item time does not depend on
// ENTRIES. Empty after reset with no clearing pass.
module sorted_range_translation_table_core #(
    parameter int ENTRIES   = 16,
    parameter int ADDR_BITS = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_op,
    input  logic [ADDR_BITS-1:0] i_address,
    input  logic [ADDR_BITS-1:0] i_end_address,
    input  logic [7:0]           i_region_id,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [2:0]           o_status,
    output logic [7:0]           o_found_id,
    output logic [ADDR_BITS-1:0] o_offset
);
    import srtt_pkg::*;

    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]           r_state;
    logic [1:0]           n_state;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [1:0]           r_op;
    logic [ADDR_BITS-1:0] r_addr;
    logic [ADDR_BITS-1:0] r_end;
    logic [7:0]           r_id;
    logic                 r_bad;
    logic                 r_out_valid;
    logic [2:0]           r_status;
    logic [2:0]           n_status;
    logic [7:0]           r_found_id;
    logic [7:0]           n_found_id;
    logic [ADDR_BITS-1:0] r_offset;
    logic [ADDR_BITS-1:0] n_offset;

    logic                 accept;
    logic                 out_free;
    logic                 commit;
    logic                 any_overlap;
    logic                 any_match;
    logic                 any_hit;
    logic                 ins_ok;
    logic                 rm_ok;
    logic [ADDR_BITS-1:0] sel_base;
    logic [7:0]           sel_tag;

    logic [ADDR_BITS-1:0] cell_base [ENTRIES];
    logic [ADDR_BITS-1:0] cell_end  [ENTRIES];
    logic [7:0]           cell_tag  [ENTRIES];
    t_cell_flags          cell_flags [ENTRIES];
    t_cell_ctl            cell_ctl  [ENTRIES];
    logic [ENTRIES-1:0]   occ;
    logic [ENTRIES-1:0]   ge;

    assign out_free = !r_out_valid || i_ready;
    assign commit   = (r_state == S_APPLY) && out_free;
    assign o_ready  = (r_state == S_IDLE) || commit;
    assign accept   = i_valid && o_ready;

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            localparam int L = (g == 0) ? 0 : g - 1;
            localparam int R = (g == ENTRIES - 1) ? g : g + 1;

            assign occ[g] = (r_count > CW'(g));

            if (g == 0) begin : g_first
                assign ge[g]                  = cell_flags[g].match;
                assign cell_ctl[g].load_new   = ins_ok && !cell_flags[g].below;
                assign cell_ctl[g].take_left  = 1'b0;
            end else begin : g_rest
                assign ge[g]                  = cell_flags[g].match || ge[g-1];
                assign cell_ctl[g].load_new   = ins_ok && !cell_flags[g].below
                                                && cell_flags[g-1].below;
                assign cell_ctl[g].take_left  = ins_ok && !cell_flags[g-1].below;
            end
            assign cell_ctl[g].take_right = rm_ok && ge[g] && (g != ENTRIES - 1);

            srtt_cell #(
                .ADDR_BITS (ADDR_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_occupied   (occ[g]),
                .i_eval       (r_state == S_EVAL),
                .i_ctl        (cell_ctl[g]),
                .i_item_addr  (r_addr),
                .i_item_end   (r_end),
                .i_item_id    (r_id),
                .i_left_base  (cell_base[L]),
                .i_left_end   (cell_end[L]),
                .i_left_tag   (cell_tag[L]),
                .i_right_base (cell_base[R]),
                .i_right_end  (cell_end[R]),
                .i_right_tag  (cell_tag[R]),
                .o_base       (cell_base[g]),
                .o_end        (cell_end[g]),
                .o_tag        (cell_tag[g]),
                .o_flags      (cell_flags[g])
            );
        end
    endgenerate

    always_comb begin
        any_overlap = 1'b0;
        any_match   = 1'b0;
        any_hit     = 1'b0;
        sel_base    = '0;
        sel_tag     = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            any_overlap = any_overlap | cell_flags[i].overlap;
            any_match   = any_match | cell_flags[i].match;
            any_hit     = any_hit | cell_flags[i].hit;
            sel_base    = sel_base | (cell_base[i] & {ADDR_BITS{cell_flags[i].hit}});
            sel_tag     = sel_tag | (cell_tag[i] & {8{cell_flags[i].hit}});
        end
    end

    always_comb begin
        n_status   = ST_NOT_FOUND;
        n_found_id = '0;
        n_offset   = '0;
        ins_ok     = 1'b0;
        rm_ok      = 1'b0;
        n_count    = r_count;
        case (r_op)
            OP_INSERT: begin
                if (r_bad) begin
                    n_status = ST_BAD_RANGE;
                end else if (any_overlap) begin
                    n_status = ST_OVERLAP;
                end else if (r_count == CW'(ENTRIES)) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_OK;
                    ins_ok   = commit;
                    n_count  = r_count + CW'(1);
                end
            end
            OP_REMOVE: begin
                if (any_match) begin
                    n_status = ST_OK;
                    rm_ok    = commit;
                    n_count  = r_count - CW'(1);
                end
            end
            OP_LOOKUP: begin
                if (any_hit) begin
                    n_status   = ST_OK;
                    n_found_id = sel_tag;
                    n_offset   = r_addr - sel_base;
                end
            end
            default: begin
                n_status = ST_NOT_FOUND;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_EVAL;
            S_EVAL:  n_state = S_APPLY;
            S_APPLY: if (commit) n_state = accept ? S_EVAL : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_op;
            r_addr <= i_address;
            r_end  <= i_end_address;
            r_id   <= i_region_id;
        end
        if (r_state == S_EVAL) begin
            r_bad <= (r_end <= r_addr);
        end
        if (commit) begin
            r_status   <= n_status;
            r_found_id <= n_found_id;
            r_offset   <= n_offset;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_status   = r_status;
    assign o_found_id = r_found_id;
    assign o_offset   = r_offset;

endmodule
